// File: design/dsu_pkg.sv
// Shared types and constants for the disjoint-set union-by-rank block.
package dsu_pkg;

  localparam int ELEM_W = 10;
  localparam int SIZE_W = 11;
  localparam int RANK_W = 4;

  localparam logic [RANK_W-1:0] RANK_SAT = 4'd15;
  localparam logic [SIZE_W-1:0] SIZE_SAT = 11'd2047;

  // Command codes
  localparam logic CMD_FIND  = 1'b0;
  localparam logic CMD_UNION = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
  } dsu_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic [SIZE_W-1:0] set_size;
    logic              merged;
  } dsu_out_t;

endpackage

// File: design/disjoint_set_union_by_rank.sv
// Find walks from element a up the parent links to its root, then compresses that path.
// Union does the same for a and then for b, then links the two roots by rank if they differ;
// walks and compression share the single node memory.
// One transaction is in work at a time; a finished result waits in the output register.
// After reset a clearing pass over all ELEMENTS entries initializes the memory; in_ready_o is low.
module disjoint_set_union_by_rank #(
  parameter int ELEMENTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsu_pkg::dsu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsu_pkg::dsu_out_t out_data_o
);
  import dsu_pkg::*;

  localparam int IW = $clog2(ELEMENTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(ELEMENTS - 1);

  typedef struct packed {
    logic [IW-1:0]     parent;
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
  } node_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WALK, ST_COMP, ST_LINK_LO, ST_LINK_HI, ST_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     clr_q, clr_d;
  logic              cmd_q, cmd_d;
  logic [IW-1:0]     a_q, a_d, b_q, b_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [IW-1:0]     root_q, root_d;
  logic              phase_b_q, phase_b_d;
  logic [IW-1:0]     ra_q, ra_d, rb_q, rb_d;
  logic [RANK_W-1:0] ra_rank_q, ra_rank_d, rb_rank_q, rb_rank_d;
  logic [SIZE_W-1:0] ra_size_q, ra_size_d, rb_size_q, rb_size_d;
  dsu_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  dsu_out_t          out_data_q, out_data_d;

  // Node memory ports
  node_t         node_mem [ELEMENTS];
  node_t         rd_data_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  node_t         wr_data;

  // Clamped input indices
  logic [IW-1:0] a_clamp, b_clamp;
  assign a_clamp = (32'(in_data_i.elem_a) >= 32'(ELEMENTS)) ? LAST_IDX : IW'(in_data_i.elem_a);
  assign b_clamp = (32'(in_data_i.elem_b) >= 32'(ELEMENTS)) ? LAST_IDX : IW'(in_data_i.elem_b);

  // Link by rank
  logic              a_hi, rank_up;
  logic [IW-1:0]     hi_idx, lo_idx;
  logic [RANK_W-1:0] hi_rank, lo_rank;
  logic [SIZE_W-1:0] lo_size, sum_sat;
  logic [SIZE_W:0]   sum_full;
  assign a_hi     = ra_rank_q > rb_rank_q;
  assign hi_idx   = a_hi ? ra_q : rb_q;
  assign lo_idx   = a_hi ? rb_q : ra_q;
  assign hi_rank  = a_hi ? ra_rank_q : rb_rank_q;
  assign lo_rank  = a_hi ? rb_rank_q : ra_rank_q;
  assign lo_size  = a_hi ? rb_size_q : ra_size_q;
  assign rank_up  = !a_hi && (ra_rank_q == rb_rank_q) && (rb_rank_q != RANK_SAT);
  assign sum_full = {1'b0, ra_size_q} + {1'b0, rb_size_q};
  assign sum_sat  = (sum_full > {1'b0, SIZE_SAT}) ? SIZE_SAT : sum_full[SIZE_W-1:0];

  // Next-state and memory control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    root_d      = root_q;
    phase_b_d   = phase_b_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    ra_rank_d   = ra_rank_q;
    rb_rank_d   = rb_rank_q;
    ra_size_d   = ra_size_q;
    rb_size_d   = rb_size_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '{parent: clr_q, rank: '0, size: SIZE_W'(1)};
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_data_i.cmd;
          a_d       = a_clamp;
          b_d       = b_clamp;
          cur_d     = a_clamp;
          phase_b_d = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = a_clamp;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (rd_data_q.parent == cur_q) begin
          // root reached: keep its rank and size, restart at the origin
          root_d = cur_q;
          if (!phase_b_q) begin
            ra_d      = cur_q;
            ra_rank_d = rd_data_q.rank;
            ra_size_d = rd_data_q.size;
          end else begin
            rb_d      = cur_q;
            rb_rank_d = rd_data_q.rank;
            rb_size_d = rd_data_q.size;
          end
          rd_addr = phase_b_q ? b_q : a_q;
          cur_d   = phase_b_q ? b_q : a_q;
          state_d = ST_COMP;
        end else begin
          rd_addr = rd_data_q.parent;
          cur_d   = rd_data_q.parent;
        end
      end
      ST_COMP: begin
        if (cur_q == root_q) begin
          if (!phase_b_q && cmd_q == CMD_UNION) begin
            rd_en     = 1'b1;
            rd_addr   = b_q;
            cur_d     = b_q;
            phase_b_d = 1'b1;
            state_d   = ST_WALK;
          end else if (!phase_b_q || ra_q == rb_q) begin
            res_d   = '{root: ELEM_W'(ra_q), set_size: ra_size_q, merged: 1'b0};
            state_d = ST_RESULT;
          end else begin
            state_d = ST_LINK_LO;
          end
        end else begin
          // point this node at the root, move on to its old parent
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = '{parent: root_q, rank: rd_data_q.rank, size: rd_data_q.size};
          rd_en   = 1'b1;
          rd_addr = rd_data_q.parent;
          cur_d   = rd_data_q.parent;
        end
      end
      ST_LINK_LO: begin
        wr_en   = 1'b1;
        wr_addr = lo_idx;
        wr_data = '{parent: hi_idx, rank: lo_rank, size: lo_size};
        state_d = ST_LINK_HI;
      end
      ST_LINK_HI: begin
        wr_en   = 1'b1;
        wr_addr = hi_idx;
        wr_data = '{parent: hi_idx, rank: hi_rank + RANK_W'(rank_up), size: sum_sat};
        res_d   = '{root: ELEM_W'(hi_idx), set_size: sum_sat, merged: 1'b1};
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cmd_q       <= CMD_FIND;
      a_q         <= '0;
      b_q         <= '0;
      cur_q       <= '0;
      root_q      <= '0;
      phase_b_q   <= 1'b0;
      ra_q        <= '0;
      rb_q        <= '0;
      ra_rank_q   <= '0;
      rb_rank_q   <= '0;
      ra_size_q   <= '0;
      rb_size_q   <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cmd_q       <= cmd_d;
      a_q         <= a_d;
      b_q         <= b_d;
      cur_q       <= cur_d;
      root_q      <= root_d;
      phase_b_q   <= phase_b_d;
      ra_q        <= ra_d;
      rb_q        <= rb_d;
      ra_rank_q   <= ra_rank_d;
      rb_rank_q   <= rb_rank_d;
      ra_size_q   <= ra_size_d;
      rb_size_q   <= rb_size_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Node memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= node_mem[rd_addr];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Compression and linking never touch the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same node");

  // Linking only happens between distinct roots
  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK_LO) |-> (ra_q != rb_q))
    else $error("link of a root to itself");

  // A merge always reports at least two elements
  a_merge_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.merged) |-> (out_data_q.set_size >= SIZE_W'(2)))
    else $error("merged set reported with size below two");

  // A new result is loaded only after the previous one left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_valid_q && !out_ready_i) |=> (state_q == ST_RESULT))
    else $error("pending result overwritten");

  // Compression writes always point at the current root
  a_comp_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && wr_en) |-> (wr_data.parent == root_q))
    else $error("compression write not aimed at root");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the disjoint-set union-by-rank block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsu_pkg::*;

  localparam int ELEMS      = 1024;
  localparam int RAND_OPS   = 1380;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 64;
  localparam int DIR_ROWS   = 23;

  // One directed row: operation plus an optional hand-typed result
  typedef struct packed {
    logic     typed;
    dsu_in_t  op;
    dsu_out_t res;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dsu_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  dsu_out_t out_data;

  // Shadow forest state
  logic [ELEM_W-1:0] link_mem [ELEMS];
  logic [RANK_W-1:0] rank_mem [ELEMS];
  logic [SIZE_W-1:0] size_mem [ELEMS];

  dsu_out_t pending_res[$];
  dir_row_t dir_tbl [DIR_ROWS];
  int       fail_cnt;
  bit       calm;
  int       hold_req;
  int       hold_done;

  disjoint_set_union_by_rank #(
    .ELEMENTS(ELEMS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock, 4 ns period
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_elem(input int v);
    return (v >= ELEMS) ? ELEMS - 1 : v;
  endfunction

  // Walk to the root, then point every node on the path at it
  function automatic int walk_root(input int start);
    int r;
    int x;
    int nxt;
    int steps;
    r = start;
    steps = 0;
    while (int'(link_mem[r]) != r && steps < ELEMS) begin
      r = clamp_elem(int'(link_mem[r]));
      steps++;
    end
    x = start;
    steps = 0;
    while (x != r && steps < ELEMS) begin
      nxt = clamp_elem(int'(link_mem[x]));
      link_mem[x] = ELEM_W'(r);
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  // Apply one find or union to the shadow forest and return its result
  function automatic dsu_out_t dsu_apply(input dsu_in_t op);
    int ra;
    int rb;
    int hi;
    int lo;
    int total;
    dsu_out_t res;
    ra = walk_root(clamp_elem(int'(op.elem_a)));
    res.root = ELEM_W'(ra);
    res.merged = 1'b0;
    if (op.cmd == CMD_UNION) begin
      rb = walk_root(clamp_elem(int'(op.elem_b)));
      if (ra != rb) begin
        if (rank_mem[ra] > rank_mem[rb]) begin
          hi = ra;
          lo = rb;
        end else begin
          hi = rb;
          lo = ra;
          if (rank_mem[ra] == rank_mem[rb] && rank_mem[rb] < RANK_SAT) begin
            rank_mem[rb] = rank_mem[rb] + 1'b1;
          end
        end
        link_mem[lo] = ELEM_W'(hi);
        total = int'(size_mem[hi]) + int'(size_mem[lo]);
        if (total > int'(SIZE_SAT)) total = int'(SIZE_SAT);
        size_mem[hi] = SIZE_W'(total);
        res.root = ELEM_W'(hi);
        res.merged = 1'b1;
      end
    end
    res.set_size = size_mem[res.root];
    return res;
  endfunction

  function automatic dir_row_t mk_row(input logic typed, input logic cmd, input int a,
                                      input int b, input int r, input int s, input logic m);
    dir_row_t row;
    row.typed = typed;
    row.op.cmd = cmd;
    row.op.elem_a = ELEM_W'(a);
    row.op.elem_b = ELEM_W'(b);
    row.res.root = ELEM_W'(r);
    row.res.set_size = SIZE_W'(s);
    row.res.merged = m;
    return row;
  endfunction

  // Element choice: local window for deep trees, full range, extremes, or a repeat
  function automatic int pick_elem(input int win_base, input int other);
    int mode;
    mode = $urandom_range(9);
    if (mode < 4) return win_base + $urandom_range(31);
    if (mode < 8) return $urandom_range(ELEMS - 1);
    if (mode == 8) return ($urandom_range(1) == 1) ? ELEMS - 1 : 0;
    return other;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result
  task automatic send_op(input dsu_in_t op, input logic typed, input dsu_out_t res);
    dsu_out_t pred;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    pred = dsu_apply(op);
    pending_res.push_back(typed ? res : pred);
    @(negedge clk);
  endtask

  // Output side: random stalls, calm window, and long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_done++;
      end else if (!calm && $urandom_range(99) < 12) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    dsu_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: root=%0d size=%0d merged=%0b",
                   out_data.root, out_data.set_size, out_data.merged);
      end else begin
        want = pending_res.pop_front();
        if (out_data.root !== want.root || out_data.set_size !== want.set_size ||
            out_data.merged !== want.merged) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp root=%0d size=%0d merged=%0b, got root=%0d size=%0d merged=%0b",
                     want.root, want.set_size, want.merged,
                     out_data.root, out_data.set_size, out_data.merged);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain
  initial begin
    dsu_in_t  op;
    dsu_out_t none;
    int       win_base;
    int       a;
    fail_cnt = 0;
    calm     = 1'b0;
    hold_req = 0;
    none     = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < ELEMS; i++) begin
      link_mem[i] = ELEM_W'(i);
      rank_mem[i] = '0;
      size_mem[i] = SIZE_W'(1);
    end

    // Fresh singletons, extremes, same-set unions, rank ties and rank order
    dir_tbl[0]  = mk_row(1, CMD_FIND,  0,    0,    0,    1, 0);
    dir_tbl[1]  = mk_row(1, CMD_FIND,  1023, 1023, 1023, 1, 0);
    dir_tbl[2]  = mk_row(1, CMD_FIND,  512,  341,  512,  1, 0);
    dir_tbl[3]  = mk_row(1, CMD_UNION, 0,    1023, 1023, 2, 1);
    dir_tbl[4]  = mk_row(1, CMD_UNION, 0,    1023, 1023, 2, 0);
    dir_tbl[5]  = mk_row(1, CMD_UNION, 1023, 1023, 1023, 2, 0);
    dir_tbl[6]  = mk_row(1, CMD_FIND,  0,    0,    1023, 2, 0);
    dir_tbl[7]  = mk_row(1, CMD_UNION, 5,    6,    6,    2, 1);
    dir_tbl[8]  = mk_row(1, CMD_UNION, 7,    6,    6,    3, 1);
    dir_tbl[9]  = mk_row(1, CMD_UNION, 6,    1023, 1023, 5, 1);
    dir_tbl[10] = mk_row(0, CMD_FIND,  5,    0,    0,    0, 0);
    dir_tbl[11] = mk_row(0, CMD_FIND,  5,    1023, 0,    0, 0);
    dir_tbl[12] = mk_row(0, CMD_UNION, 1023, 8,    0,    0, 0);
    dir_tbl[13] = mk_row(0, CMD_UNION, 9,    10,   0,    0, 0);
    dir_tbl[14] = mk_row(0, CMD_UNION, 11,   12,   0,    0, 0);
    dir_tbl[15] = mk_row(0, CMD_UNION, 9,    11,   0,    0, 0);
    dir_tbl[16] = mk_row(0, CMD_UNION, 13,   9,    0,    0, 0);
    dir_tbl[17] = mk_row(0, CMD_UNION, 9,    0,    0,    0, 0);
    dir_tbl[18] = mk_row(0, CMD_FIND,  10,   0,    0,    0, 0);
    dir_tbl[19] = mk_row(0, CMD_FIND,  12,   1023, 0,    0, 0);
    dir_tbl[20] = mk_row(0, CMD_UNION, 341,  682,  0,    0, 0);
    dir_tbl[21] = mk_row(0, CMD_UNION, 682,  341,  0,    0, 0);
    dir_tbl[22] = mk_row(0, CMD_FIND,  682,  1023, 0,    0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(dir_tbl[i].op, dir_tbl[i].typed, dir_tbl[i].res);
    end

    // Random traffic; window moves so that local trees grow deep before merging
    win_base = 0;
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i % 100 == 0) win_base = $urandom_range(ELEMS - 32);
      if (i == 200) hold_req++;
      calm = (i >= 600 && i < 850);
      op.cmd    = ($urandom_range(99) < 55) ? CMD_UNION : CMD_FIND;
      a         = pick_elem(win_base, $urandom_range(ELEMS - 1));
      op.elem_a = ELEM_W'(a);
      op.elem_b = ELEM_W'(pick_elem(win_base, a));
      send_op(op, 1'b0, none);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
